// ===== rtl/lps_pkg.sv =====
// Package for the line position PID steering block: widths, register indexes and the position table.
package lps_pkg;

  // Depth of the error history that forms the integral term.
  localparam int HISTORY_DEPTH  = 6;
  // Fraction bits of the unsigned fixed-point gains.
  localparam int GAIN_FRAC_BITS = 12;

  // Fixed field widths.
  localparam int POS_W      = 9;
  localparam int ERR_W      = 10;
  localparam int DERIV_W    = 11;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 8;
  localparam int CORR_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived widths of the arithmetic path.
  localparam int HIST_IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int INTEG_W    = ERR_W + $clog2(HISTORY_DEPTH);
  localparam int MUL_A_W    = (INTEG_W > DERIV_W) ? INTEG_W : DERIV_W;
  localparam int PROD_W     = MUL_A_W + GAIN_W + 1;
  localparam int ACC_W      = PROD_W + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET    = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_GAIN_I    = 3'd3,
    REG_MAX_SPEED = 3'd4
  } cfg_reg_e;

  // Register reset values.
  localparam logic [POS_W-1:0]   TARGET_RST    = 9'd200;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd983;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd18956;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd10;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd100;

  // Line lost: the last position decides which edge the line went off.
  localparam logic [POS_W-1:0] POS_LOST_LIMIT = 9'd200;
  localparam logic [POS_W-1:0] POS_FAR_LEFT   = 9'd400;
  localparam logic [POS_W-1:0] POS_FAR_RIGHT  = 9'd0;

  // Weighted centroid of the lit sensors, truncated. The index is
  // {far left, left, centre, right, far right}. No sensor lit is handled
  // outside the table.
  function automatic logic [POS_W-1:0] pos_lookup(input logic [4:0] seen);
    logic [POS_W-1:0] pos;
    case (seen)
      5'd1:    pos = 9'd0;
      5'd2:    pos = 9'd100;
      5'd3:    pos = 9'd50;
      5'd4:    pos = 9'd200;
      5'd5:    pos = 9'd100;
      5'd6:    pos = 9'd150;
      5'd7:    pos = 9'd100;
      5'd8:    pos = 9'd300;
      5'd9:    pos = 9'd150;
      5'd10:   pos = 9'd200;
      5'd11:   pos = 9'd133;
      5'd12:   pos = 9'd250;
      5'd13:   pos = 9'd166;
      5'd14:   pos = 9'd200;
      5'd15:   pos = 9'd150;
      5'd16:   pos = 9'd400;
      5'd17:   pos = 9'd200;
      5'd18:   pos = 9'd250;
      5'd19:   pos = 9'd166;
      5'd20:   pos = 9'd300;
      5'd21:   pos = 9'd200;
      5'd22:   pos = 9'd233;
      5'd23:   pos = 9'd175;
      5'd24:   pos = 9'd350;
      5'd25:   pos = 9'd233;
      5'd26:   pos = 9'd266;
      5'd27:   pos = 9'd200;
      5'd28:   pos = 9'd300;
      5'd29:   pos = 9'd225;
      5'd30:   pos = 9'd250;
      5'd31:   pos = 9'd200;
      default: pos = POS_FAR_RIGHT;
    endcase
    return pos;
  endfunction

endpackage

// ===== rtl/line_position_pid_steering.sv =====
// Line position PID steering: sequencer, shared multiply-accumulate unit and output register.
// The block works on one sample at a time: after an input transfer it walks the error history
// taps, makes three passes through the one shared multiplier and scales the sum, and it takes
// no new sample until the result has been loaded into the output register.
// The next input is taken while a finished result still waits in the output register.
// Reset (asynchronous, active low) loads the register defaults and clears the position, error
// and error history state.
module line_position_pid_steering
  import lps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Sensor sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  far_left_seen_i,
  input  logic                  left_seen_i,
  input  logic                  center_seen_i,
  input  logic                  right_seen_i,
  input  logic                  far_right_seen_i,
  // Steering result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      line_position_o,
  output logic signed [CORR_W-1:0] correction_o,
  output logic [SPEED_W-1:0]    left_duty_o,
  output logic [SPEED_W-1:0]    right_duty_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INTEG = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Multiplier passes: proportional, derivative, integral, then the final add.
  localparam logic [1:0] TERM_P    = 2'd0;
  localparam logic [1:0] TERM_D    = 2'd1;
  localparam logic [1:0] TERM_I    = 2'd2;
  localparam logic [1:0] TERM_LAST = 2'd3;

  localparam logic [HIST_IDX_W-1:0] HIST_LAST = HIST_IDX_W'(HISTORY_DEPTH - 1);

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [POS_W-1:0]   target_q;
  logic [GAIN_W-1:0]  gain_p_q, gain_d_q, gain_i_q;
  logic [SPEED_W-1:0] max_speed_q;

  // Controller state.
  logic [POS_W-1:0]        prev_pos_q;
  logic signed [ERR_W-1:0] prev_err_q;
  logic signed [ERR_W-1:0] hist_q [HISTORY_DEPTH];

  // Working registers of one item.
  logic [POS_W-1:0]          pos_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DERIV_W-1:0] deriv_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic [HIST_IDX_W-1:0]     idx_q;
  logic [1:0]                term_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [SPEED_W-1:0]        mag_q;
  logic                      neg_q;

  // Output register.
  logic                      out_valid_q;
  logic [POS_W-1:0]          out_pos_q;
  logic signed [CORR_W-1:0]  out_corr_q;
  logic [SPEED_W-1:0]        out_left_q, out_right_q;

  logic                      in_xfer;
  logic                      out_load;
  logic [4:0]                seen;
  logic [POS_W-1:0]          pos_new;
  logic signed [ERR_W-1:0]   err_new;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic [ACC_W-1:0]          acc_abs;
  logic [ACC_W-1:0]          mag_full;
  logic [SPEED_W-1:0]        mag_new;
  logic [SPEED_W-1:0]        duty_cut;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Position of the new sample, with the line-lost rule.
  assign seen = {far_left_seen_i, left_seen_i, center_seen_i, right_seen_i, far_right_seen_i};
  always_comb begin
    if (seen == 5'd0) begin
      pos_new = (prev_pos_q <= POS_LOST_LIMIT) ? POS_FAR_RIGHT : POS_FAR_LEFT;
    end else begin
      pos_new = pos_lookup(seen);
    end
  end
  assign err_new = $signed({1'b0, pos_new}) - $signed({1'b0, target_q});

  // Shared multiplier operand selection.
  always_comb begin
    case (term_q)
      TERM_P: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = gain_p_q;
      end
      TERM_D: begin
        mul_a = MUL_A_W'(deriv_q);
        mul_b = gain_d_q;
      end
      default: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = gain_i_q;
      end
    endcase
  end
  assign mul_prod = mul_a * $signed({1'b0, mul_b});

  // Scale toward zero and clamp the magnitude to the maximum speed.
  assign acc_abs  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign mag_full = acc_abs >> GAIN_FRAC_BITS;
  assign mag_new  = (mag_full > ACC_W'(max_speed_q)) ? max_speed_q : mag_full[SPEED_W-1:0];
  assign duty_cut = max_speed_q - mag_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_INTEG;
      ST_INTEG: if (idx_q == HIST_LAST) state_d = ST_MUL;
      ST_MUL:   if (term_q == TERM_LAST) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RST;
      gain_p_q    <= GAIN_P_RST;
      gain_d_q    <= GAIN_D_RST;
      gain_i_q    <= GAIN_I_RST;
      max_speed_q <= MAX_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET:    target_q    <= cfg_wdata_i[POS_W-1:0];
        REG_GAIN_P:    gain_p_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_MAX_SPEED: max_speed_q <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state: the history shifts once the integral walk has read it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= POS_FAR_RIGHT;
      prev_err_q <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (in_xfer) begin
        prev_pos_q <= pos_new;
      end
      if (state_q == ST_INTEG && idx_q == HIST_LAST) begin
        prev_err_q <= err_q;
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
          hist_q[k] <= hist_q[k-1];
        end
        hist_q[0] <= err_q;
      end
    end
  end

  // Item working registers and the shared multiply-accumulate unit.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        pos_q   <= pos_new;
        err_q   <= err_new;
        deriv_q <= DERIV_W'(err_new) - DERIV_W'(prev_err_q);
        integ_q <= '0;
        idx_q   <= '0;
      end
      ST_INTEG: begin
        integ_q <= integ_q + INTEG_W'(hist_q[idx_q]);
        idx_q   <= idx_q + 1'b1;
        term_q  <= TERM_P;
        acc_q   <= '0;
      end
      ST_MUL: begin
        if (term_q != TERM_P) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
        if (term_q != TERM_LAST) begin
          prod_q <= mul_prod;
        end
        term_q <= term_q + 1'b1;
      end
      ST_SCALE: begin
        mag_q <= mag_new;
        neg_q <= acc_q[ACC_W-1];
      end
      default: ;
    endcase
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pos_q   <= pos_q;
      out_corr_q  <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
      out_left_q  <= neg_q ? max_speed_q : duty_cut;
      out_right_q <= neg_q ? duty_cut : max_speed_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_position_o = out_pos_q;
  assign correction_o    = out_corr_q;
  assign left_duty_o     = out_left_q;
  assign right_duty_o    = out_right_q;

  // The block works on one item at a time after a sample transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("sample taken while an item is still in progress");

  // One motor always keeps the full duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_duty_o == max_speed_q || right_duty_o == max_speed_q))
    else $error("neither motor runs at the base duty");

  // The reported position stays within the sensor span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_position_o <= POS_FAR_LEFT))
    else $error("line position beyond the far left sensor");

  // A new result is loaded only after the scaling step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> $past(state_q == ST_SCALE) || $past(state_q == ST_OUT))
    else $error("result loaded without a scaling step");

endmodule

// ===== dv/tb_line_position_pid_steering.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the line position PID steering block, with its own steering predictor.
module tb_line_position_pid_steering
  import lps_pkg::*;
();

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = HISTORY_DEPTH + 20;

  // Directed sensor patterns {far left, left, centre, right, far right}: every single
  // sensor, all lit, and the line lost after positions on both sides of the lost limit.
  localparam logic [4:0] DIRECTED [21] = '{
    5'b00000, 5'b10000, 5'b00000, 5'b01000, 5'b00100, 5'b00000, 5'b00010,
    5'b00001, 5'b00000, 5'b11111, 5'b11000, 5'b00011, 5'b10001, 5'b01110,
    5'b00110, 5'b00000, 5'b11100, 5'b00000, 5'b10101, 5'b01010, 5'b11011
  };

  typedef struct {
    logic [POS_W-1:0]         pos;
    logic signed [CORR_W-1:0] corr;
    logic [SPEED_W-1:0]       left;
    logic [SPEED_W-1:0]       right;
  } steer_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i      = '0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_ready_o;
  logic                     far_left_seen_i  = 1'b0;
  logic                     left_seen_i      = 1'b0;
  logic                     center_seen_i    = 1'b0;
  logic                     right_seen_i     = 1'b0;
  logic                     far_right_seen_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i      = 1'b0;
  logic [POS_W-1:0]         line_position_o;
  logic signed [CORR_W-1:0] correction_o;
  logic [SPEED_W-1:0]       left_duty_o;
  logic [SPEED_W-1:0]       right_duty_o;

  line_position_pid_steering dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .far_left_seen_i  (far_left_seen_i),
    .left_seen_i      (left_seen_i),
    .center_seen_i    (center_seen_i),
    .right_seen_i     (right_seen_i),
    .far_right_seen_i (far_right_seen_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .line_position_o  (line_position_o),
    .correction_o     (correction_o),
    .left_duty_o      (left_duty_o),
    .right_duty_o     (right_duty_o)
  );

  always #10 clk_i = ~clk_i;

  // Register copies and controller state of the predictor.
  int target_q, gain_p_q, gain_d_q, gain_i_q, max_speed_q;
  int last_pos, last_err;
  int err_hist [HISTORY_DEPTH];

  logic [4:0] sample_queue [$];
  steer_t     steer_expected [$];
  logic [4:0] offered;
  steer_t     due;
  int         fail_count = 0;
  bit         idling = 1'b1;
  bit         hold_off_req = 1'b0;
  int         gap_left, stall_left, hold_left;
  int         walk_k = 4;
  int         lost_left = 0;

  // Predicts the steering result of one sample and advances the controller state.
  function automatic steer_t steer_predict(input logic [4:0] seen);
    int     lit, wsum, pos, err, deriv, integ;
    longint acc, corr;
    steer_t res;
    lit  = $countones(seen);
    wsum = 0;
    // Bit k of the sample carries weight 100 * k, so the far right sensor adds nothing.
    for (int k = 1; k < 5; k++) begin
      if (seen[k]) wsum += 100 * k;
    end
    if (lit == 0) begin
      pos = (last_pos <= int'(POS_LOST_LIMIT)) ? int'(POS_FAR_RIGHT) : int'(POS_FAR_LEFT);
    end else begin
      pos = wsum / lit;
    end
    last_pos = pos;
    err   = pos - target_q;
    deriv = err - last_err;
    integ = 0;
    foreach (err_hist[k]) integ += err_hist[k];
    last_err = err;
    for (int k = HISTORY_DEPTH - 1; k > 0; k--) err_hist[k] = err_hist[k-1];
    err_hist[0] = err;
    acc = longint'(err) * gain_p_q + longint'(deriv) * gain_d_q + longint'(integ) * gain_i_q;
    // Scale the exact sum down, truncating toward zero.
    corr = (acc < 0) ? -((-acc) >>> GAIN_FRAC_BITS) : (acc >>> GAIN_FRAC_BITS);
    if (corr > max_speed_q) corr = max_speed_q;
    else if (corr < -max_speed_q) corr = -max_speed_q;
    res.pos  = POS_W'(pos);
    res.corr = CORR_W'(corr);
    if (corr < 0) begin
      res.left  = SPEED_W'(max_speed_q);
      res.right = SPEED_W'(max_speed_q + corr);
    end else begin
      res.left  = SPEED_W'(max_speed_q - corr);
      res.right = SPEED_W'(max_speed_q);
    end
    return res;
  endfunction

  // Mostly a line drifting smoothly under the sensor bar, with spells of lost line and noise.
  function automatic logic [4:0] track_sample();
    int         r, step, s;
    logic [4:0] v;
    r = $urandom_range(0, 99);
    if (lost_left > 0) begin
      lost_left--;
      return '0;
    end
    if (r < 8) begin
      lost_left = $urandom_range(0, 3);
      return '0;
    end
    if (r < 25) return 5'($urandom);
    step = $urandom_range(0, 2);
    walk_k += step - 1;
    if (walk_k < 0) walk_k = 0;
    if (walk_k > 8) walk_k = 8;
    // Even steps light one sensor, odd steps two neighbours.
    s = walk_k / 2;
    v = 5'b10000 >> s;
    if (walk_k % 2 == 1) v |= 5'b01000 >> s;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_TARGET:    target_q    = int'(value[POS_W-1:0]);
      REG_GAIN_P:    gain_p_q    = int'(value[GAIN_W-1:0]);
      REG_GAIN_D:    gain_d_q    = int'(value[GAIN_W-1:0]);
      REG_GAIN_I:    gain_i_q    = int'(value[GAIN_W-1:0]);
      REG_MAX_SPEED: max_speed_q = int'(value[SPEED_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input int tgt, input int gp, input int gd, input int gi,
                                input int vmax);
    cfg_write(REG_TARGET, CFG_DATA_W'(tgt));
    cfg_write(REG_GAIN_P, CFG_DATA_W'(gp));
    cfg_write(REG_GAIN_D, CFG_DATA_W'(gd));
    cfg_write(REG_GAIN_I, CFG_DATA_W'(gi));
    cfg_write(REG_MAX_SPEED, CFG_DATA_W'(vmax));
  endtask

  // Checked between edges, once every update of the clock edge has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || steer_expected.size() != 0);
    @(posedge clk_i);
  endtask

  // Sample driver: offers queued samples, holding each until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {far_left_seen_i, left_seen_i, center_seen_i, right_seen_i, far_right_seen_i} <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) steer_expected.push_back(steer_predict(offered));
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          offered = sample_queue.pop_front();
          {far_left_seen_i, left_seen_i, center_seen_i, right_seen_i, far_right_seen_i}
            <= offered;
          in_valid_i <= 1'b1;
          gap_left = idling ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest prediction and paces ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (steer_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual pos %0d corr %0d",
                   $time, line_position_o, correction_o);
          fail_count++;
        end else begin
          due = steer_expected.pop_front();
          check_field("line_position", int'(due.pos), int'(line_position_o));
          check_field("correction", int'(due.corr), int'(correction_o));
          check_field("left_duty", int'(due.left), int'(left_duty_o));
          check_field("right_duty", int'(due.right), int'(right_duty_o));
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idling && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus: reset, then phases of sensor samples, each after phase 0 preceded by new register settings.
  initial begin
    target_q    = int'(TARGET_RST);
    gain_p_q    = int'(GAIN_P_RST);
    gain_d_q    = int'(GAIN_D_RST);
    gain_i_q    = int'(GAIN_I_RST);
    max_speed_q = int'(MAX_SPEED_RST);
    last_pos    = 0;
    last_err    = 0;
    foreach (err_hist[k]) err_hist[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      idling = (ph != 1 && ph != 7);
      case (ph)
        0: foreach (DIRECTED[k]) sample_queue.push_back(DIRECTED[k]);
        1: apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        2: apply_settings(0, 0, 0, 0, 0);
        3: apply_settings(400, 4096, 0, 4096, 255);
        4: begin
          apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
          // Writes to unused indexes must leave every register alone.
          for (int k = REG_MAX_SPEED + 1; k < 2 ** CFG_IDX_W; k++) begin
            cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
          end
        end
        5: apply_settings($urandom_range(0, 400), $urandom_range(0, 8192),
                          $urandom_range(0, 32768), $urandom_range(0, 256),
                          $urandom_range(1, 255));
        6: apply_settings($urandom_range(0, 511), $urandom, $urandom, $urandom, $urandom);
        default: apply_settings(int'(TARGET_RST), int'(GAIN_P_RST), int'(GAIN_D_RST),
                                int'(GAIN_I_RST), int'(MAX_SPEED_RST));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) sample_queue.push_back(track_sample());
      // Hold the result side off so that the block fills and stalls its input.
      if (ph == 3) hold_off_req = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && steer_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lps_pkg.sv
rtl/line_position_pid_steering.sv
dv/tb_line_position_pid_steering.sv
